// ===== sv/gtrc_pkg.sv =====
// ----------------------------------------------------------------------------
// gtrc_pkg: shared types and constants of the generation-tagged result cache
// Beat payloads, the cache entry layout, operation and query codes, and the
// one-at-a-time hash helpers.
// ----------------------------------------------------------------------------
package gtrc_pkg;

   // Operation codes carried in the request beat
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_FILL   = 2'd1;
   localparam logic [1:0] OP_FRAME  = 2'd2;

   // Query kinds
   localparam logic [1:0] KIND_SPHERE_A = 2'd0;
   localparam logic [1:0] KIND_SPHERE_B = 2'd1;
   localparam logic [1:0] KIND_POINT    = 2'd2;

   localparam logic [31:0] KIND_CONST_SPHERE_A = 32'h0098_39E0;
   localparam logic [31:0] KIND_CONST_SPHERE_B = 32'h0098_3A60;
   localparam logic [31:0] KIND_CONST_POINT    = 32'h0098_3D70;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [1:0]          query_kind;
      logic [31:0]         coord_x;
      logic [31:0]         coord_y;
      logic [31:0]         coord_z;
      logic [31:0]         radius;
      logic signed [31:0]  fill_value;
   } gtrc_req_type;

   typedef struct packed {
      logic                hit;
      logic signed [31:0]  cached_value;
   } gtrc_rsp_type;

   // Word 0 is x, then y, z and radius
   typedef logic [3:0][31:0] gtrc_key_type;

   typedef struct packed {
      logic [31:0]   tag;
      gtrc_key_type  coords;
      logic [31:0]   value;
      logic [31:0]   gen;
   } gtrc_entry_type;

   function automatic logic [31:0] kind_const(input logic [1:0] kind);
      logic [31:0] kc;
      case (kind)
         KIND_SPHERE_A: kc = KIND_CONST_SPHERE_A;
         KIND_SPHERE_B: kc = KIND_CONST_SPHERE_B;
         KIND_POINT:    kc = KIND_CONST_POINT;
         default:       kc = '0;
      endcase
      return kc;
   endfunction

   // One byte of the one-at-a-time mix
   function automatic logic [31:0] oaat_round(input logic [31:0] h_in, input logic [7:0] b);
      logic [31:0] h;
      h = h_in + {24'd0, b};
      h = h + (h << 10);
      h = h ^ (h >> 6);
      return h;
   endfunction

   // Add the kind constant, then the closing avalanche
   function automatic logic [31:0] oaat_final(input logic [31:0] h_in, input logic [31:0] kc);
      logic [31:0] h;
      h = h_in + kc;
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      return h;
   endfunction

   // NaN never equal, signed zeros equal, else bitwise
   function automatic logic ieee_equal(input logic [31:0] a, input logic [31:0] b);
      logic a_nan;
      logic b_nan;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      if (a_nan || b_nan) begin
         return 1'b0;
      end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
         return 1'b1;
      end else begin
         return a == b;
      end
   endfunction

endpackage

// ===== sv/gtrc_chan_if.sv =====
// ----------------------------------------------------------------------------
// gtrc_chan_if: valid/ready channel
// Carries one beat of payload_type when valid and ready are both high.
// ----------------------------------------------------------------------------
interface gtrc_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== sv/generation_tagged_result_cache_core.sv =====
// ----------------------------------------------------------------------------
// generation_tagged_result_cache_core: direct-mapped memo cache
// Caches visibility results keyed by query kind and four float words, with a
// generation tag that a frame start bumps to drop every entry at once.
// ----------------------------------------------------------------------------
// Usage: each request beat gives exactly one response beat, in order. A lookup
// answers hit with the stored value, or a miss with zero; a fill and a frame
// start answer hit 0 with value 0, as do the unused opcode and query kind.
// The key is hashed with a one-at-a-time mix over the 16 coordinate bytes
// (x, y, z, radius, little-endian; radius taken as +0.0 for point queries),
// and the low hash bits select one of CACHE_SLOTS entries held in a single
// synchronous memory. Items are taken one at a time: a lookup or a fill passes
// from accept through the hash state, which folds two key bytes per pass, then
// the mix state for the closing mix with the memory access, then the compare
// (lookup) or done (fill) state that loads the response; a frame start or an
// ignored item goes from accept straight to the done state. The response sits
// in an output register, so the next request is accepted while the previous
// response waits to be taken. After reset the block clears the memory, one
// entry a cycle, before req_if.ready rises.
// ----------------------------------------------------------------------------
module generation_tagged_result_cache_core
   import gtrc_pkg::*;
#(
   parameter int CACHE_SLOTS = 16384
) (
   input  logic           clock,
   input  logic           reset,
   gtrc_chan_if.sink      req_if,
   gtrc_chan_if.source    rsp_if
);

   localparam int IDX_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
   // Index mask as the hash is masked, and the last slot of the clear pass
   localparam logic [IDX_W-1:0] SLOT_MASK = IDX_W'(CACHE_SLOTS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_MIX,
      ST_LOOK,
      ST_DONE
   } state_type;

   // Control
   state_type        state_ff,   state_in;
   logic [2:0]       cnt_ff,     cnt_in;
   logic [IDX_W-1:0] clr_ff,     clr_in;
   logic [31:0]      gen_ff,     gen_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Item in flight
   logic [1:0]       op_ff,      op_in;
   logic [1:0]       kind_ff,    kind_in;
   gtrc_key_type     key_ff,     key_in;
   logic [31:0]      fill_ff,    fill_in;
   logic [31:0]      hash_ff,    hash_in;

   // Response register
   logic             rsp_hit_ff,   rsp_hit_in;
   logic [31:0]      rsp_value_ff, rsp_value_in;

   // Entry memory
   gtrc_entry_type   mem [CACHE_SLOTS];
   gtrc_entry_type   rd_ff;
   logic             mem_we;
   logic             mem_re;
   logic [IDX_W-1:0] mem_wa;
   logic [IDX_W-1:0] mem_ra;
   gtrc_entry_type   mem_wd;

   logic             req_fire;
   logic             out_free;
   logic             rsp_load;
   logic [31:0]      mix_hash;
   logic [IDX_W-1:0] slot;
   logic [31:0]      hash_word;
   logic [7:0]       byte_lo;
   logic [7:0]       byte_hi;
   logic             lookup_hit;
   logic             req_kind_ok;

   assign req_if.ready   = (state_ff == ST_IDLE);
   assign req_fire       = req_if.valid && req_if.ready;
   assign out_free       = !rsp_valid_ff || rsp_if.ready;
   assign rsp_load       = out_free && ((state_ff == ST_LOOK) || (state_ff == ST_DONE));
   assign req_kind_ok    = (req_if.payload.query_kind == KIND_SPHERE_A)
                        || (req_if.payload.query_kind == KIND_SPHERE_B)
                        || (req_if.payload.query_kind == KIND_POINT);

   // Two key bytes per hash cycle: cnt picks the word and the half
   assign hash_word = key_ff[cnt_ff[2:1]];
   assign byte_lo   = cnt_ff[0] ? hash_word[23:16] : hash_word[7:0];
   assign byte_hi   = cnt_ff[0] ? hash_word[31:24] : hash_word[15:8];

   assign mix_hash  = oaat_final(hash_ff, kind_const(kind_ff));
   assign slot      = mix_hash[IDX_W-1:0] & SLOT_MASK;

   // Hit: tag, generation and all four words must agree
   always_comb begin
      lookup_hit = (rd_ff.tag == hash_ff) && (rd_ff.gen == gen_ff);
      for (int i = 0; i < 4; i++) begin
         lookup_hit = lookup_hit && ieee_equal(rd_ff.coords[i], key_ff[i]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      gen_in       = gen_ff;
      op_in        = op_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      fill_in      = fill_ff;
      hash_in      = hash_ff;
      // drop the response once the sink takes the beat
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_wa       = clr_ff;
      mem_ra       = slot;
      mem_wd       = '0;

      case (state_ff)
         ST_CLEAR: begin
            // zero one entry a cycle
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            if (clr_ff == SLOT_MASK) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_if.payload.opcode;
               kind_in  = req_if.payload.query_kind;
               key_in[0] = req_if.payload.coord_x;
               key_in[1] = req_if.payload.coord_y;
               key_in[2] = req_if.payload.coord_z;
               key_in[3] = (req_if.payload.query_kind == KIND_POINT) ? 32'd0
                                                                    : req_if.payload.radius;
               fill_in  = $unsigned(req_if.payload.fill_value);
               hash_in  = '0;
               cnt_in   = '0;
               if (req_if.payload.opcode == OP_FRAME) begin
                  gen_in   = gen_ff + 32'd1;
                  state_in = ST_DONE;
               end else if (((req_if.payload.opcode == OP_LOOKUP)
                          || (req_if.payload.opcode == OP_FILL)) && req_kind_ok) begin
                  state_in = ST_HASH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_HASH: begin
            hash_in = oaat_round(oaat_round(hash_ff, byte_lo), byte_hi);
            cnt_in  = cnt_ff + 1'b1;
            if (&cnt_ff) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            hash_in = mix_hash;
            if (op_ff == OP_FILL) begin
               mem_we        = 1'b1;
               mem_wa        = slot;
               mem_wd.tag    = mix_hash;
               mem_wd.coords = key_ff;
               mem_wd.value  = fill_ff;
               mem_wd.gen    = gen_ff;
               state_in      = ST_DONE;
            end else begin
               mem_re   = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            // hold the read entry until the response register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = lookup_hit;
               rsp_value_in = lookup_hit ? rd_ff.value : 32'd0;
               state_in     = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_value_in = 32'd0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         gen_ff       <= 32'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      kind_ff      <= kind_in;
      key_ff       <= key_in;
      fill_ff      <= fill_in;
      hash_ff      <= hash_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   assign rsp_if.valid                = rsp_valid_ff;
   assign rsp_if.payload.hit          = rsp_hit_ff;
   assign rsp_if.payload.cached_value = $signed(rsp_value_ff);

`ifndef SYNTHESIS
   // A hit can only come out of the compare state
   a_hit_from_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_load && (state_ff == ST_DONE) |=> !rsp_if.payload.hit)
      else $error("hit reported for a non-lookup item");

   // Responses are loaded only from the compare or done states
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past((state_ff == ST_LOOK) || (state_ff == ST_DONE)))
      else $error("response raised outside the answer states");

   // The generation moves only on an accepted frame start beat
   a_gen_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(gen_ff)
         |-> $past(req_fire && (req_if.payload.opcode == OP_FRAME))
          && (gen_ff == $past(gen_ff) + 32'd1))
      else $error("generation changed without a frame start");

   // The memory is never written while a lookup compares its entry or while idle
   a_no_write_in_look: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) || (state_ff == ST_IDLE) |-> !mem_we)
      else $error("entry memory written outside clear or fill");
`endif

endmodule

// ===== test/generation_tagged_result_cache_core_tb.sv =====
// ----------------------------------------------------------------------------
// generation_tagged_result_cache_core_tb: self-checking bench for the memo cache
// Drives lookups, fills, frame starts and unused codes through the request
// channel. A predictor of its own keeps a copy of the cache and the current
// generation, works out each answer, and checks every response beat in order.
// ----------------------------------------------------------------------------
module generation_tagged_result_cache_core_tb;
   import gtrc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS           = 16384;
   // Must cover the clearing pass after reset plus ~850 beats at worst-case
   // latency, gaps and stalls, with a wide margin.
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 30;
   localparam int POOL_DEPTH      = 48;

   // Codes the package leaves unnamed: the spare opcode and query kind
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gtrc_chan_if #(.payload_type(gtrc_req_type)) req_if ();
   gtrc_chan_if #(.payload_type(gtrc_rsp_type)) rsp_if ();

   generation_tagged_result_cache_core #(
      .CACHE_SLOTS(SLOTS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Predicted cache contents
   // --------------------------------------------------------------------------
   logic [31:0]  slot_tag [SLOTS];
   gtrc_key_type slot_key [SLOTS];
   logic [31:0]  slot_val [SLOTS];
   logic [31:0]  slot_gen [SLOTS];
   logic [31:0]  frame_gen;

   gtrc_rsp_type pending_answers [$];   // answers still owed by the block
   gtrc_req_type key_pool [$];          // recently filled keys, for lookups to reuse
   int           mismatches = 0;
   bit           gaps_on = 1'b0;
   int           burst_left = 0;
   bit           hold_off_request = 1'b0;

   // Radius is taken as +0.0 for point queries
   function automatic gtrc_key_type query_key(input gtrc_req_type b);
      gtrc_key_type k;
      k[0] = b.coord_x;
      k[1] = b.coord_y;
      k[2] = b.coord_z;
      k[3] = (b.query_kind == KIND_POINT) ? 32'd0 : b.radius;
      return k;
   endfunction

   // One-at-a-time mix over 16 bytes, little-endian, x first, then the
   // kind's constant and the closing avalanche
   function automatic logic [31:0] key_digest(input gtrc_key_type k, input logic [1:0] kind);
      logic [31:0] h;
      logic [31:0] seed;
      h = '0;
      for (int w = 0; w < 4; w++) begin
         for (int n = 0; n < 4; n++) begin
            h = h + {24'd0, k[w][8*n +: 8]};
            h = h + (h << 10);
            h = h ^ (h >> 6);
         end
      end
      case (kind)
         KIND_SPHERE_A: seed = KIND_CONST_SPHERE_A;
         KIND_SPHERE_B: seed = KIND_CONST_SPHERE_B;
         default:       seed = KIND_CONST_POINT;
      endcase
      h = h + seed;
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      return h;
   endfunction

   function automatic int unsigned slot_of(input gtrc_req_type b);
      return key_digest(query_key(b), b.query_kind) & (SLOTS - 1);
   endfunction

   // Float equality on raw words: NaN matches nothing, signed zeros match
   function automatic logic floats_match(input logic [31:0] a, input logic [31:0] b);
      logic a_nan;
      logic b_nan;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
      if (a_nan || b_nan) return 1'b0;
      if (a[30:0] == '0 && b[30:0] == '0) return 1'b1;
      return a == b;
   endfunction

   // Apply one accepted request to the predicted cache and return its answer
   function automatic gtrc_rsp_type predict_answer(input gtrc_req_type b);
      gtrc_rsp_type ans;
      gtrc_key_type k;
      logic [31:0]  digest;
      int unsigned  slot;
      logic         match;
      ans = '0;
      if (b.opcode == OP_FRAME) begin
         frame_gen = frame_gen + 32'd1;
         return ans;
      end
      if (b.opcode == OP_UNUSED || b.query_kind == KIND_UNUSED) return ans;
      k      = query_key(b);
      digest = key_digest(k, b.query_kind);
      slot   = digest & (SLOTS - 1);
      if (b.opcode == OP_LOOKUP) begin
         match = (slot_tag[slot] == digest) && (slot_gen[slot] == frame_gen);
         for (int w = 0; w < 4; w++) begin
            match = match && floats_match(slot_key[slot][w], k[w]);
         end
         if (match) begin
            ans.hit          = 1'b1;
            ans.cached_value = slot_val[slot];
         end
      end else begin
         slot_tag[slot] = digest;
         slot_key[slot] = k;
         slot_val[slot] = b.fill_value;
         slot_gen[slot] = frame_gen;
      end
      return ans;
   endfunction

   // --------------------------------------------------------------------------
   // Stimulus helpers
   // --------------------------------------------------------------------------
   function automatic gtrc_req_type make_beat(input logic [1:0] op, input logic [1:0] kind,
                                              input logic [31:0] x, input logic [31:0] y,
                                              input logic [31:0] z, input logic [31:0] r,
                                              input logic [31:0] v);
      gtrc_req_type b;
      b.opcode     = op;
      b.query_kind = kind;
      b.coord_x    = x;
      b.coord_y    = y;
      b.coord_z    = z;
      b.radius     = r;
      b.fill_value = v;
      return b;
   endfunction

   // Bias words towards zeros, infinities, NaNs and the all-ones corners
   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'h8000_0000;
         2:       return {1'($urandom_range(1)), 8'hFF, 23'd0};
         3:       return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(23'h7F_FFFF, 1))};
         4:       return 32'hFFFF_FFFF;
         5:       return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Mostly fills followed by lookups of the same keys, with frame starts and
   // unused codes mixed in as noise
   function automatic gtrc_req_type random_beat();
      gtrc_req_type b;
      gtrc_req_type p;
      int           pick;
      pick = $urandom_range(99);
      b = make_beat(OP_LOOKUP, 2'($urandom_range(2)), pick_word(), pick_word(), pick_word(),
                    pick_word(), pick_word());
      if (pick < 3) begin
         b.opcode = OP_FRAME;
      end else if (pick < 5) begin
         b.opcode = OP_UNUSED;
      end else if (pick < 8) begin
         b.opcode     = ($urandom_range(1) != 0) ? OP_FILL : OP_LOOKUP;
         b.query_kind = KIND_UNUSED;
      end else if (pick < 45) begin
         b.opcode = OP_FILL;
         if (key_pool.size() != 0 && $urandom_range(1) != 0) begin
            p = key_pool[$urandom_range(key_pool.size() - 1)];
            b.query_kind = p.query_kind;
            b.coord_x    = p.coord_x;
            b.coord_y    = p.coord_y;
            b.coord_z    = p.coord_z;
            b.radius     = p.radius;
         end
         key_pool.push_back(b);
         if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
      end else if (pick < 85 && key_pool.size() != 0) begin
         p = key_pool[$urandom_range(key_pool.size() - 1)];
         b.query_kind = p.query_kind;
         b.coord_x    = p.coord_x;
         b.coord_y    = p.coord_y;
         b.coord_z    = p.coord_z;
         b.radius     = p.radius;
         // Perturb now and then: a new radius, a flipped zero sign, another kind
         case ($urandom_range(9))
            0: b.radius = $urandom;
            1: if (b.coord_x[30:0] == '0) b.coord_x[31] = ~b.coord_x[31];
            2: b.query_kind = 2'($urandom_range(2));
            default: ;
         endcase
      end
      return b;
   endfunction

   // Offer one beat and hold it until the block takes it. In gap mode the
   // sender idles between bursts of random length.
   task automatic issue_beat(input gtrc_req_type b);
      int gap;
      if (gaps_on) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(8, 1);
            burst_left = $urandom_range(12, 1);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left--;
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= b;
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   // Search for a key of the same kind landing in the slot of the given one
   function automatic gtrc_req_type slot_partner(input gtrc_req_type a);
      gtrc_req_type c;
      c = a;
      do c.coord_y = $urandom;
      while (slot_of(c) != slot_of(a) || c.coord_y == a.coord_y);
      return c;
   endfunction

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------
   task automatic test_directed_cases();
      gtrc_req_type a;
      gtrc_req_type partner;
      gaps_on = 1'b0;
      a = make_beat(OP_FILL, KIND_SPHERE_A, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000,
                    32'h3F00_0000, 32'h7FFF_FFFF);
      // Fresh cache: generation 0 everywhere, so even the all-zero key misses
      issue_beat(make_beat(OP_LOOKUP, KIND_SPHERE_A, '0, '0, '0, '0, '0));
      issue_beat(a);
      a.opcode = OP_LOOKUP;
      issue_beat(a);
      // Same words under another kind hash differently
      issue_beat(make_beat(OP_LOOKUP, KIND_SPHERE_B, a.coord_x, a.coord_y, a.coord_z,
                           a.radius, '0));
      // Point queries ignore the radius
      issue_beat(make_beat(OP_FILL, KIND_POINT, 32'hC120_0000, 32'h0000_0001, 32'h4F00_0000,
                           32'h1234_5678, 32'h8000_0000));
      issue_beat(make_beat(OP_LOOKUP, KIND_POINT, 32'hC120_0000, 32'h0000_0001, 32'h4F00_0000,
                           32'hFFFF_FFFF, '0));
      // All-ones words are NaNs and never match
      issue_beat(make_beat(OP_FILL, KIND_SPHERE_B, '1, '1, '1, '1, '1));
      issue_beat(make_beat(OP_LOOKUP, KIND_SPHERE_B, '1, '1, '1, '1, '0));
      // Infinities and signed zeros compare by value
      issue_beat(make_beat(OP_FILL, KIND_SPHERE_B, 32'h7F80_0000, 32'hFF80_0000, 32'h0,
                           32'h7F7F_FFFF, 32'h0));
      issue_beat(make_beat(OP_LOOKUP, KIND_SPHERE_B, 32'h7F80_0000, 32'hFF80_0000, 32'h0,
                           32'h7F7F_FFFF, 32'h0));
      issue_beat(make_beat(OP_LOOKUP, KIND_SPHERE_B, 32'h7F80_0000, 32'hFF80_0000,
                           32'h8000_0000, 32'h7F7F_FFFF, 32'h0));
      // Spare kind and spare opcode leave the cache alone and answer zero
      issue_beat(make_beat(OP_FILL, KIND_UNUSED, a.coord_x, a.coord_y, a.coord_z, a.radius,
                           32'd5));
      issue_beat(make_beat(OP_LOOKUP, KIND_UNUSED, a.coord_x, a.coord_y, a.coord_z, a.radius,
                           '0));
      issue_beat(make_beat(OP_UNUSED, KIND_SPHERE_A, a.coord_x, a.coord_y, a.coord_z,
                           a.radius, 32'd9));
      // Another key in the same slot evicts the first
      partner = slot_partner(a);
      partner.opcode     = OP_FILL;
      partner.fill_value = 32'd77;
      issue_beat(partner);
      issue_beat(a);
      partner.opcode = OP_LOOKUP;
      issue_beat(partner);
      // A frame start drops everything; a refill brings the key back
      issue_beat(make_beat(OP_FRAME, KIND_SPHERE_A, '0, '0, '0, '0, '0));
      issue_beat(partner);
      partner.opcode     = OP_FILL;
      partner.fill_value = 32'd78;
      issue_beat(partner);
      partner.opcode = OP_LOOKUP;
      issue_beat(partner);
      issue_beat(make_beat(OP_LOOKUP, KIND_POINT, '0, '0, '0, '0, '0));
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering,
   // so the output register fills and the block stalls its input
   task automatic test_output_hold_off();
      gaps_on          = 1'b0;
      hold_off_request = 1'b1;
      repeat (48) issue_beat(random_beat());
   endtask

   task automatic test_random_traffic();
      for (int chunk = 0; chunk < 13; chunk++) begin
         gaps_on = ($urandom_range(3) != 0);
         repeat (60) issue_beat(random_beat());
      end
   endtask

   // --------------------------------------------------------------------------
   // Receiver: ready follows a pattern of its own, switching now and then
   // --------------------------------------------------------------------------
   initial begin : receiver
      rx_mode_type mode;
      int          mode_left;
      int          phase;
      int          stall_left;
      mode       = RX_STEADY;
      mode_left  = 0;
      phase      = 0;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) begin
               @(posedge clock);
               rsp_if.ready <= 1'b0;
            end
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(3));
               mode_left = $urandom_range(300, 40);
            end
            mode_left--;
            phase++;
            case (mode)
               RX_STEADY:   rsp_if.ready <= 1'b1;
               RX_RANDOM:   rsp_if.ready <= ($urandom_range(99) < 65);
               RX_PERIODIC: rsp_if.ready <= ((phase % 7) >= 3);
               default: begin
                  // Mostly ready, with an occasional stall whose length is drawn at random
                  if (stall_left == 0 && $urandom_range(99) < 10) begin
                     stall_left = $urandom_range(12, 1);
                  end
                  if (stall_left != 0) begin
                     stall_left--;
                     rsp_if.ready <= 1'b0;
                  end else begin
                     rsp_if.ready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // --------------------------------------------------------------------------
   // Monitor: check response beats in order, predict each accepted request
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      gtrc_rsp_type want;
      gtrc_rsp_type got;
      if (!reset) begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got = rsp_if.payload;
            if (pending_answers.size() == 0) begin
               if (mismatches < 10) begin
                  $display("%0t: response beat hit %0b value %0d with nothing outstanding",
                           $realtime, got.hit, got.cached_value);
               end
               mismatches++;
            end else begin
               want = pending_answers.pop_front();
               if (got.hit !== want.hit || got.cached_value !== want.cached_value) begin
                  if (mismatches < 10) begin
                     $display("%0t: mismatch: hit exp %0b got %0b, value exp %0d got %0d",
                              $realtime, want.hit, got.hit, want.cached_value,
                              got.cached_value);
                  end
                  mismatches++;
               end
            end
         end
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            pending_answers.push_back(predict_answer(req_if.payload));
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("** generation_tagged_result_cache_core: FAILED **");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin : main
      int settle;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      foreach (slot_tag[i]) begin
         slot_tag[i] = '0;
         slot_key[i] = '0;
         slot_val[i] = '0;
         slot_gen[i] = '0;
      end
      frame_gen = 32'd1;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_output_hold_off();
      test_random_traffic();
      req_if.valid <= 1'b0;

      // Drain what is owed, then give the pipeline time to show any extra beat
      settle = 0;
      while (pending_answers.size() != 0 && settle < 100000) begin
         @(posedge clock);
         settle++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_answers.size() != 0) begin
         if (mismatches < 10) begin
            $display("%0d answers never arrived", pending_answers.size());
         end
         mismatches += pending_answers.size();
      end

      if (mismatches == 0) begin
         $display("** generation_tagged_result_cache_core: PASSED **");
      end else begin
         $display("** generation_tagged_result_cache_core: FAILED **");
      end
      $finish;
   end

endmodule
